>>> rtl/btgc_pkg.sv
package btgc_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TAP_WINDOW = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_PRESS = 2'd2;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_WIDTH-1:0] TAP_WINDOW_RST = 16'd300;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 16'd1000;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SINGLE = 2'd1,
        GEST_DOUBLE = 2'd2,
        GEST_LONG   = 2'd3
    } t_gesture;

endpackage

>>> rtl/button_tap_gesture_classifier_top.sv
// Button tap gesture classifier.
// Input stream (s_axis): one request per millisecond tick carrying the sampled
// button level (0 = pressed). Output stream (m_axis): one gesture code per
// input request: none, single tap, double tap or long press.
// Configuration: write-only port, i_cfg_wr_en with i_cfg_addr selecting
// debounce (0), tap window (1) or long press (2) tick counts; other
// indexes are ignored. Write only while the block is idle.
// The gesture of a tick appears on m_axis in the cycle after the
// input request is accepted. Throughput: one tick per cycle while
// m_axis_tready is high, set by the single output register; timeout
// compares, debounce and the tick counter update all close in the same cycle.
// Reset (synchronous, active low): tick counter, press/release/change
// times clear, debounced level goes to released, registers return to
// 50/300/1000 and the output is empty.
// Stall: while a result waits on a low m_axis_tready, s_axis_tready is
// low; as soon as the result is taken in a cycle a new request is taken too.
module button_tap_gesture_classifier_top #(
    parameter int TIME_WIDTH = btgc_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [btgc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_addr,
    input  logic [btgc_pkg::CFG_WIDTH-1:0]      i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [0] level
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata    // [1:0] gesture
);

    logic [btgc_pkg::CFG_WIDTH-1:0] r_debounce;
    logic [btgc_pkg::CFG_WIDTH-1:0] r_tap_window;
    logic [btgc_pkg::CFG_WIDTH-1:0] r_long_press;

    logic [TIME_WIDTH-1:0] r_tick, n_tick;
    logic [TIME_WIDTH-1:0] r_press, n_press;
    logic [TIME_WIDTH-1:0] r_release, n_release;
    logic [TIME_WIDTH-1:0] r_change, n_change;
    logic                  r_stable, n_stable;

    logic                  r_valid;
    btgc_pkg::t_gesture    r_gesture, n_gesture;

    logic [TIME_WIDTH-1:0] since_release;
    logic [TIME_WIDTH-1:0] since_press;
    logic [TIME_WIDTH-1:0] since_change;
    logic                  level;
    logic                  accept;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign level         = s_axis_tdata[0];

    assign since_release = r_tick - r_release;
    assign since_press   = r_tick - r_press;
    assign since_change  = r_tick - r_change;

    always_comb begin
        n_gesture = btgc_pkg::GEST_NONE;
        n_press   = r_press;
        n_release = r_release;
        n_change  = r_change;
        n_stable  = r_stable;
        n_tick    = r_tick + TIME_WIDTH'(1);

        if (r_release != '0 && r_press != '0 &&
            since_release > TIME_WIDTH'(r_long_press)) begin
            n_gesture = btgc_pkg::GEST_LONG;
            n_press   = '0;
            n_release = '0;
        end else if (r_press != '0 && since_press > TIME_WIDTH'(r_tap_window)) begin
            n_gesture = btgc_pkg::GEST_SINGLE;
            n_press   = '0;
            n_release = '0;
        end

        if (level != r_stable && since_change > TIME_WIDTH'(r_debounce)) begin
            n_stable = level;
            n_change = r_tick;
            if (!level) begin
                if (n_press != '0) begin
                    n_gesture = btgc_pkg::GEST_DOUBLE;
                    n_press   = '0;
                    n_release = '0;
                end else begin
                    n_press = (r_tick == '0) ? TIME_WIDTH'(1) : r_tick;
                end
            end else begin
                n_release = r_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= btgc_pkg::DEBOUNCE_RST;
            r_tap_window <= btgc_pkg::TAP_WINDOW_RST;
            r_long_press <= btgc_pkg::LONG_PRESS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                btgc_pkg::REG_DEBOUNCE:   r_debounce   <= i_cfg_wdata;
                btgc_pkg::REG_TAP_WINDOW: r_tap_window <= i_cfg_wdata;
                btgc_pkg::REG_LONG_PRESS: r_long_press <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_press   <= '0;
            r_release <= '0;
            r_change  <= '0;
            r_stable  <= 1'b1;
        end else if (accept) begin
            r_tick    <= n_tick;
            r_press   <= n_press;
            r_release <= n_release;
            r_change  <= n_change;
            r_stable  <= n_stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gesture <= n_gesture;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'b0, r_gesture};

endmodule

>>> rtl/btgc_checker.sv
module btgc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_wr_en,
    input logic [btgc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_addr,
    input logic [btgc_pkg::CFG_WIDTH-1:0]      i_cfg_wdata,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [7:0]                          s_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [7:0]                          m_axis_tdata
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output slot");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request gave no result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready) && m_axis_tready |=> !m_axis_tvalid)
        else $error("result appeared without request");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind button_tap_gesture_classifier_top btgc_checker u_btgc_checker (.*);
